FILE: rtl/core/plps_pkg.sv
package plps_pkg;

  // Grid and number format
  localparam int MAX_DIM   = 32;
  localparam int FRAC_BITS = 24;
  localparam int VAL_W     = 32;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int POS_W     = 5;
  localparam int SIZE_W    = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

  // Effective size spans 1..MAX_DIM; a wrapped coordinate spans 0..MAX_DIM-1
  localparam int ESW   = $clog2(MAX_DIM + 1);
  localparam int CW    = ($clog2(MAX_DIM) > POS_W) ? $clog2(MAX_DIM) : POS_W;
  localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  // Six neighbour sum and its division by six
  localparam int NB_COUNT   = 6;
  localparam int NB_CNT_W   = $clog2(NB_COUNT + 1);
  localparam int SUM_W      = VAL_W + 3;
  localparam int DIVISOR    = 6;
  localparam int DIV_STEP   = 7;
  localparam int DIV_CYCLES = SUM_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // Item operations
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X,
    REG_SIZE_Y,
    REG_SIZE_Z
  } cfg_reg_e;

endpackage

FILE: rtl/core/plps_div6.sv
module plps_div6
  import plps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  output logic             done_o,
  output logic [VAL_W-1:0] quot_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0]     d_q;
  logic [2:0]           r_q;
  logic [SUM_W-1:0]     d_d;
  logic [2:0]           r_d;

  // Restoring division by a constant: the remainder stays below the divisor,
  // so each step is a narrow compare and subtract
  always_comb begin
    logic [3:0] t;
    d_d = d_q;
    r_d = r_q;
    for (int i = 0; i < DIV_STEP; i++) begin
      t   = {r_d, d_d[SUM_W-1]};
      d_d = {d_d[SUM_W-2:0], 1'b0};
      if (t >= 4'(DIVISOR)) begin
        t      = t - 4'(DIVISOR);
        d_d[0] = 1'b1;
      end
      r_d = t[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      d_q    <= '0;
      r_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        d_q    <= dividend_i;
        r_q    <= '0;
      end else if (busy_q) begin
        d_q   <= d_d;
        r_q   <= r_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = d_q[VAL_W-1:0];

endmodule

FILE: rtl/core/periodic_lattice_propagator_step_unit.sv
// Seven-point lattice propagator step over a periodic 3D grid.
// Input channel (in_valid_i / in_stall_o) carries one item per handshake.
// A load item (op_i = 0) writes q_value_i and weight_i for voxel
// (pos_x_i, pos_y_i, pos_z_i) into two single-port voxel memories and
// returns one item with new_value_o = 0. A compute item (op_i = 1) reads
// the six face neighbours from the value memory, one per cycle, wrapping on
// each axis, divides their sum by six, multiplies by the voxel's weight and
// returns the Q8.24 product, clipped to all ones with saturated_o set.
// Coordinates are first reduced modulo the effective grid size.
//
// A load passes ST_PREP, ST_LOAD and ST_FIN; a compute passes ST_PREP,
// ST_READ, ST_DIV, ST_MUL, ST_SAT and ST_FIN. One item is in flight at a time,
// so a new item is taken the cycle after the previous one reaches the output
// register. The six neighbour reads through one memory port and the divider
// make a compute take longer than a load.
// The output register holds its item while out_stall_i is high; the unit
// keeps working on the next item and waits only to hand its result over.
// Reset returns the grid sizes to 8 and empties the pipeline; the voxel
// memories are not cleared and must be loaded before they are read.
// The user must write grid sizes through cfg_* only while the unit is idle; the unit does not enforce this.
module periodic_lattice_propagator_step_unit
  import plps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [POS_W-1:0]     pos_x_i,
  input  logic [POS_W-1:0]     pos_y_i,
  input  logic [POS_W-1:0]     pos_z_i,
  input  logic [VAL_W-1:0]     q_value_i,
  input  logic [VAL_W-1:0]     weight_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [VAL_W-1:0]     new_value_o,
  output logic                 saturated_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_READ,
    ST_DIV,
    ST_MUL,
    ST_SAT,
    ST_FIN
  } st_e;

  // Clamp a size register to 1..MAX_DIM
  function automatic logic [ESW-1:0] eff_size(logic [SIZE_W-1:0] raw);
    logic [ESW-1:0] n;
    if (raw == '0) begin
      n = ESW'(1);
    end else if (int'(raw) > MAX_DIM) begin
      n = ESW'(MAX_DIM);
    end else begin
      n = ESW'(raw);
    end
    return n;
  endfunction

  // Remainder of a coordinate by the grid size, one bit per step
  function automatic logic [CW-1:0] wrap_pos(logic [POS_W-1:0] p, logic [ESW-1:0] n);
    logic [ESW:0] r;
    r = '0;
    for (int i = POS_W - 1; i >= 0; i--) begin
      r = {r[ESW-1:0], p[i]};
      if (r >= {1'b0, n}) begin
        r = r - {1'b0, n};
      end
    end
    return CW'(r);
  endfunction

  function automatic logic [CW-1:0] next_pos(logic [CW-1:0] p, logic [ESW-1:0] n);
    logic [CW-1:0] q;
    if (int'(p) + 1 >= int'(n)) begin
      q = '0;
    end else begin
      q = CW'(int'(p) + 1);
    end
    return q;
  endfunction

  function automatic logic [CW-1:0] prev_pos(logic [CW-1:0] p, logic [ESW-1:0] n);
    logic [CW-1:0] q;
    if (p == '0) begin
      q = CW'(int'(n) - 1);
    end else begin
      q = CW'(int'(p) - 1);
    end
    return q;
  endfunction

  function automatic logic [AW-1:0] addr_of(logic [CW-1:0] x, logic [CW-1:0] y,
                                            logic [CW-1:0] z);
    return AW'((int'(x) * MAX_DIM + int'(y)) * MAX_DIM + int'(z));
  endfunction

  // Configuration
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [ESW-1:0]    nx, ny, nz;

  // Item and datapath registers
  st_e                 state_q;
  logic                op_q;
  logic [POS_W-1:0]    raw_x_q, raw_y_q, raw_z_q;
  logic [VAL_W-1:0]    qv_q, wt_q;
  logic [CW-1:0]       px_q, py_q, pz_q;
  logic [NB_CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SUM_W-1:0]    sum_d;
  logic [VAL_W-1:0]    w_q;
  logic [PROD_W-1:0]   prod_q;
  logic [PROD_W-1:0]   prod_d;
  logic [VAL_W-1:0]    res_val_q;
  logic                res_sat_q;
  logic                out_valid_q;
  logic [VAL_W-1:0]    out_val_q;
  logic                out_sat_q;

  // Memory ports
  logic [VAL_W-1:0] q_mem [DEPTH];
  logic [VAL_W-1:0] w_mem [DEPTH];
  logic             st_we;
  logic             q_re;
  logic             w_re;
  logic [AW-1:0]    here_addr;
  logic [AW-1:0]    q_raddr;
  logic [VAL_W-1:0] q_rdata_q;
  logic [VAL_W-1:0] w_rdata_q;

  // Divider
  logic             div_start;
  logic             div_done;
  logic [VAL_W-1:0] avg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RESET;
      size_y_q <= SIZE_RESET;
      size_z_q <= SIZE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SIZE_X: size_x_q <= cfg_data_i;
        REG_SIZE_Y: size_y_q <= cfg_data_i;
        REG_SIZE_Z: size_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign nx = eff_size(size_x_q);
  assign ny = eff_size(size_y_q);
  assign nz = eff_size(size_z_q);

  assign here_addr = addr_of(px_q, py_q, pz_q);

  // Walk the six face neighbours: +x, -x, +y, -y, +z, -z
  always_comb begin
    case (cnt_q)
      NB_CNT_W'(0): q_raddr = addr_of(next_pos(px_q, nx), py_q, pz_q);
      NB_CNT_W'(1): q_raddr = addr_of(prev_pos(px_q, nx), py_q, pz_q);
      NB_CNT_W'(2): q_raddr = addr_of(px_q, next_pos(py_q, ny), pz_q);
      NB_CNT_W'(3): q_raddr = addr_of(px_q, prev_pos(py_q, ny), pz_q);
      NB_CNT_W'(4): q_raddr = addr_of(px_q, py_q, next_pos(pz_q, nz));
      default:      q_raddr = addr_of(px_q, py_q, prev_pos(pz_q, nz));
    endcase
  end

  assign st_we = (state_q == ST_LOAD);
  assign q_re  = (state_q == ST_READ) && (cnt_q < NB_CNT_W'(NB_COUNT));
  assign w_re  = (state_q == ST_READ) && (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      q_mem[here_addr] <= qv_q;
    end
    if (q_re) begin
      q_rdata_q <= q_mem[q_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      w_mem[here_addr] <= wt_q;
    end
    if (w_re) begin
      w_rdata_q <= w_mem[here_addr];
    end
  end

  // Read data is registered and arrives in the cycle after its address; the last neighbour lands
  // together with the divider start
  assign sum_d     = sum_q + SUM_W'(q_rdata_q);
  assign div_start = (state_q == ST_READ) && (cnt_q == NB_CNT_W'(NB_COUNT));

  plps_div6 u_div6 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .done_o     (div_done),
    .quot_o     (avg)
  );

  assign prod_d = PROD_W'(w_q) * PROD_W'(avg);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_LOAD;
      raw_x_q     <= '0;
      raw_y_q     <= '0;
      raw_z_q     <= '0;
      qv_q        <= '0;
      wt_q        <= '0;
      px_q        <= '0;
      py_q        <= '0;
      pz_q        <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      w_q         <= '0;
      prod_q      <= '0;
      res_val_q   <= '0;
      res_sat_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      // Drop the output item once taken; a handoff below may refill it
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q    <= op_i;
            raw_x_q <= pos_x_i;
            raw_y_q <= pos_y_i;
            raw_z_q <= pos_z_i;
            qv_q    <= q_value_i;
            wt_q    <= weight_i;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          px_q    <= wrap_pos(raw_x_q, nx);
          py_q    <= wrap_pos(raw_y_q, ny);
          pz_q    <= wrap_pos(raw_z_q, nz);
          cnt_q   <= '0;
          state_q <= (op_q == OP_LOAD) ? ST_LOAD : ST_READ;
        end
        ST_LOAD: begin
          res_val_q <= '0;
          res_sat_q <= 1'b0;
          state_q   <= ST_FIN;
        end
        ST_READ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == '0) begin
            sum_q <= '0;
          end else begin
            sum_q <= sum_d;
          end
          if (cnt_q == NB_CNT_W'(1)) begin
            w_q <= w_rdata_q;
          end
          if (div_start) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= prod_d;
          state_q <= ST_SAT;
        end
        ST_SAT: begin
          if ((prod_q >> (VAL_W + FRAC_BITS)) != '0) begin
            res_val_q <= '1;
            res_sat_q <= 1'b1;
          end else begin
            res_val_q <= prod_q[FRAC_BITS +: VAL_W];
            res_sat_q <= 1'b0;
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          // Hand over once the output register is free or being emptied
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_val_q   <= res_val_q;
            out_sat_q   <= res_sat_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign new_value_o = out_val_q;
  assign saturated_o = out_sat_q;

  // Wrapped coordinates stay inside the grid while the memories are addressed
  a_pos_in_grid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD || state_q == ST_READ) |->
      (int'(px_q) < int'(nx) && int'(py_q) < int'(ny) && int'(pz_q) < int'(nz)))
    else $error("wrapped coordinate outside grid");

  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside its wait state");

  a_read_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> cnt_q <= NB_CNT_W'(NB_COUNT))
    else $error("neighbour counter ran past the last neighbour");

  a_handoff : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && (!out_valid_q || !out_stall_i)) |=>
      (state_q == ST_IDLE && out_valid_q))
    else $error("result not handed to the output register");

  a_write_on_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> (op_q == OP_LOAD && $past(state_q) == ST_PREP))
    else $error("memory write outside a load item");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import plps_pkg::*;

  // Run limits and timing
  localparam int          LONG_HOLD      = 400;   // receiver hold-off under back pressure
  localparam int          WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
  localparam int          DRAIN_CYCLES   = 40;    // settle time after the last result
  localparam int          GAP_MAX        = 18;
  localparam int          PHASE_COUNT    = 10;
  localparam int          PHASE_ITEMS    = 100;

  localparam logic [VAL_W-1:0]     VAL_MAX     = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0]     UNIT_WEIGHT = VAL_W'(1) << FRAC_BITS;   // 1.0 in Q8.24
  // The one register index the unit does not decode
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = {CFG_IDX_W{1'b1}};

  typedef struct {
    logic             op;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [VAL_W-1:0] q_value;
    logic [VAL_W-1:0] weight;
  } voxel_item_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             saturated;
  } step_result_t;

  // DUT connections; every input starts from a known value
  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [SIZE_W-1:0]    cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 op          = OP_LOAD;
  logic [POS_W-1:0]     pos_x       = '0;
  logic [POS_W-1:0]     pos_y       = '0;
  logic [POS_W-1:0]     pos_z       = '0;
  logic [VAL_W-1:0]     q_value     = '0;
  logic [VAL_W-1:0]     weight      = '0;
  logic                 out_stall   = 1'b1;
  logic                 cfg_ready_o;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [VAL_W-1:0]     new_value_o;
  logic                 saturated_o;

  // Mirror of the unit: grid sizes and both voxel stores
  logic [SIZE_W-1:0] size_x_cfg = SIZE_RESET;
  logic [SIZE_W-1:0] size_y_cfg = SIZE_RESET;
  logic [SIZE_W-1:0] size_z_cfg = SIZE_RESET;
  logic [VAL_W-1:0]  q_mirror [DEPTH];
  logic [VAL_W-1:0]  w_mirror [DEPTH];
  bit                loaded   [DEPTH];

  // Propagated values still owed by the unit, oldest first
  step_result_t propagated_q [$];

  int unsigned items_sent    = 0;
  int unsigned fail_count    = 0;
  int unsigned quiet_cycles  = 0;
  bit          tx_idle_en    = 1'b1;
  bit          rx_idle_en    = 1'b1;
  bit          long_hold_req = 1'b0;

  periodic_lattice_propagator_step_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .op_i        (op),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .pos_z_i     (pos_z),
    .q_value_i   (q_value),
    .weight_i    (weight),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .new_value_o (new_value_o),
    .saturated_o (saturated_o)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Grid arithmetic
  // ---------------------------------------------------------------------------

  // A size of zero acts as one, anything above MAX_DIM as MAX_DIM
  function automatic int extent(input logic [SIZE_W-1:0] raw);
    if (raw == '0) return 1;
    if (int'(raw) > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  function automatic int wrap_up(input int p, input int n);
    return (p + 1 >= n) ? 0 : p + 1;
  endfunction

  function automatic int wrap_down(input int p, input int n);
    return (p == 0) ? n - 1 : p - 1;
  endfunction

  function automatic int voxel_addr(input int x, input int y, input int z);
    return (x * MAX_DIM + y) * MAX_DIM + z;
  endfunction

  // Apply one item to the mirror and return the result it owes
  function automatic step_result_t propagate_step(input voxel_item_t it);
    int              nx, ny, nz, x, y, z, here;
    logic [SUM_W-1:0]  nb_sum;
    logic [VAL_W-1:0]  avg;
    logic [PROD_W-1:0] prod;
    step_result_t      res;
    nx   = extent(size_x_cfg);
    ny   = extent(size_y_cfg);
    nz   = extent(size_z_cfg);
    x    = int'(it.pos_x) % nx;
    y    = int'(it.pos_y) % ny;
    z    = int'(it.pos_z) % nz;
    here = voxel_addr(x, y, z);
    res.value     = '0;
    res.saturated = 1'b0;
    if (it.op == OP_LOAD) begin
      q_mirror[here] = it.q_value;
      w_mirror[here] = it.weight;
      loaded[here]   = 1'b1;
    end else begin
      nb_sum = SUM_W'(q_mirror[voxel_addr(wrap_up(x, nx), y, z)])
             + SUM_W'(q_mirror[voxel_addr(wrap_down(x, nx), y, z)])
             + SUM_W'(q_mirror[voxel_addr(x, wrap_up(y, ny), z)])
             + SUM_W'(q_mirror[voxel_addr(x, wrap_down(y, ny), z)])
             + SUM_W'(q_mirror[voxel_addr(x, y, wrap_up(z, nz))])
             + SUM_W'(q_mirror[voxel_addr(x, y, wrap_down(z, nz))]);
      avg  = VAL_W'(nb_sum / DIVISOR);
      prod = (PROD_W'(w_mirror[here]) * PROD_W'(avg)) >> FRAC_BITS;
      // Clip anything that does not fit the 32-bit result
      if (|prod[PROD_W-1:VAL_W]) begin
        res.value     = VAL_MAX;
        res.saturated = 1'b1;
      end else begin
        res.value = prod[VAL_W-1:0];
      end
    end
    return res;
  endfunction

  // Mix of full-range, moderate, unit-range and extreme Q8.24 values
  function automatic logic [VAL_W-1:0] draw_q8_24();
    case ($urandom_range(0, 3))
      0: return VAL_W'($urandom);
      1: return VAL_W'($urandom_range(0, (1 << (FRAC_BITS + 1)) - 1));
      2: return ($urandom_range(0, 1) != 0) ? VAL_MAX : '0;
      default: return VAL_W'($urandom_range(0, 1 << FRAC_BITS));
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_extent();
    case ($urandom_range(0, 9))
      0: return SIZE_W'($urandom_range(0, 1));
      1: return SIZE_W'($urandom_range(MAX_DIM, (1 << SIZE_W) - 1));
      default: return SIZE_W'($urandom_range(2, 6));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one item after a random gap when idling is on, and hold it until the unit takes it.
  // Valid stays high into the next item when no gap is drawn.
  task automatic send_item(input voxel_item_t it);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, GAP_MAX) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= it.op;
    pos_x    <= it.pos_x;
    pos_y    <= it.pos_y;
    pos_z    <= it.pos_z;
    q_value  <= it.q_value;
    weight   <= it.weight;
    do @(posedge clk); while (in_stall_o);
    propagated_q.push_back(propagate_step(it));
    items_sent++;
  endtask

  task automatic load_voxel(input logic [POS_W-1:0] px, py, pz,
                            input logic [VAL_W-1:0] qv, wv);
    voxel_item_t it;
    it = '{op: OP_LOAD, pos_x: px, pos_y: py, pos_z: pz, q_value: qv, weight: wv};
    send_item(it);
  endtask

  task automatic compute_voxel(input logic [POS_W-1:0] px, py, pz);
    voxel_item_t it;
    // Value fields are don't-care on a compute; toggle them anyway
    it = '{op: OP_COMPUTE, pos_x: px, pos_y: py, pos_z: pz,
           q_value: VAL_W'($urandom), weight: VAL_W'($urandom)};
    send_item(it);
  endtask

  // Fill in whatever the stencil would read that was never loaded, then compute
  task automatic compute_at(input logic [POS_W-1:0] px, py, pz);
    int nx, ny, nz, x, y, z;
    int cx [7];
    int cy [7];
    int cz [7];
    nx = extent(size_x_cfg);
    ny = extent(size_y_cfg);
    nz = extent(size_z_cfg);
    x  = int'(px) % nx;
    y  = int'(py) % ny;
    z  = int'(pz) % nz;
    cx = '{x, wrap_up(x, nx), wrap_down(x, nx), x, x, x, x};
    cy = '{y, y, y, wrap_up(y, ny), wrap_down(y, ny), y, y};
    cz = '{z, z, z, z, z, wrap_up(z, nz), wrap_down(z, nz)};
    for (int k = 0; k < 7; k++) begin
      if (!loaded[voxel_addr(cx[k], cy[k], cz[k])]) begin
        load_voxel(POS_W'(cx[k]), POS_W'(cy[k]), POS_W'(cz[k]), draw_q8_24(), draw_q8_24());
      end
    end
    compute_voxel(px, py, pz);
  endtask

  task automatic random_item();
    if ($urandom_range(0, 9) < 6) begin
      compute_at(POS_W'($urandom_range(0, 31)), POS_W'($urandom_range(0, 31)),
                 POS_W'($urandom_range(0, 31)));
    end else begin
      load_voxel(POS_W'($urandom_range(0, 31)), POS_W'($urandom_range(0, 31)),
                 POS_W'($urandom_range(0, 31)), draw_q8_24(), draw_q8_24());
    end
  endtask

  // Drop valid and wait until every owed result has been handed over
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (propagated_q.size() != 0);
  endtask

  // Write all three sizes, then the undecoded index, which must change nothing
  task automatic set_grid(input logic [SIZE_W-1:0] sx, sy, sz);
    logic [CFG_IDX_W-1:0] idx_list [4];
    logic [SIZE_W-1:0]    val_list [4];
    wait_drained();
    idx_list = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z, REG_UNUSED};
    val_list = '{sx, sy, sz, SIZE_W'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[k];
      cfg_data  <= val_list[k];
      do @(posedge clk); while (!cfg_ready_o);
      case (idx_list[k])
        REG_SIZE_X: size_x_cfg = val_list[k];
        REG_SIZE_Y: size_y_cfg = val_list[k];
        REG_SIZE_Z: size_z_cfg = val_list[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Stall a random number of cycles before each result when idling is on; on request, hold off
  // for a long stretch so the unit backs up into its input.
  initial begin : result_receiver
    int unsigned hold;
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end
      hold = rx_idle_en ? $urandom_range(0, GAP_MAX) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid_o);
    end
  end

  // Compare each handed-over result with the oldest owed one
  always @(posedge clk) begin : check_results
    step_result_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (propagated_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got new_value %h saturated %b",
                 $time, new_value_o, saturated_o);
        fail_count++;
      end else begin
        want = propagated_q.pop_front();
        if (new_value_o !== want.value) begin
          $display("%0t: new_value mismatch, expected %h, got %h",
                   $time, want.value, new_value_o);
          fail_count++;
        end
        if (saturated_o !== want.saturated) begin
          $display("%0t: saturated mismatch, expected %b, got %b",
                   $time, want.saturated, saturated_o);
          fail_count++;
        end
      end
    end
  end

  // End the run if no channel moves for too long
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset sizes of 8: wrap at both ends and out-of-range coordinates on all three axes of the load
  task automatic test_default_grid();
    load_voxel(POS_W'(15), POS_W'(8), POS_W'(31), draw_q8_24(), UNIT_WEIGHT);
    compute_at(POS_W'(7), POS_W'(0), POS_W'(31));
  endtask

  // Size zero and size one collapse the grid to one voxel that is its own
  // neighbour on every axis; covers saturation and the exact all-ones edge.
  task automatic test_unit_grid();
    set_grid('0, SIZE_W'(1), SIZE_W'(1));
    load_voxel('1, '1, '1, VAL_MAX, VAL_MAX);
    compute_voxel(POS_W'(5), POS_W'(17), POS_W'(30));
    load_voxel('0, '0, '0, VAL_MAX, '0);
    compute_voxel('0, '0, '0);
    load_voxel(POS_W'(9), '0, POS_W'(2), VAL_W'(6) << FRAC_BITS, UNIT_WEIGHT);
    compute_voxel('1, '0, '0);
    // Largest value times 1.0 fits exactly and must not flag
    load_voxel('0, '1, '0, VAL_MAX, UNIT_WEIGHT);
    compute_voxel('0, '0, '1);
  endtask

  // Sizes above MAX_DIM clamp; compute at the far corner so all axes wrap
  task automatic test_oversize_grid();
    set_grid('1, SIZE_W'(MAX_DIM + 1), SIZE_W'(MAX_DIM));
    load_voxel('1, '1, '1, draw_q8_24(), UNIT_WEIGHT >> 1);
    compute_at('1, '1, '1);
  endtask

  // Receiver holds off while the sender streams without gaps
  task automatic test_back_pressure();
    set_grid(SIZE_W'(4), SIZE_W'(4), SIZE_W'(4));
    tx_idle_en    = 1'b0;
    rx_idle_en    = 1'b1;
    long_hold_req = 1'b1;
    repeat (40) random_item();
  endtask

  // Random sizes per phase, with idling on either side switched per phase
  task automatic test_random_traffic();
    int unsigned phase_start;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      set_grid(pick_extent(), pick_extent(), pick_extent());
      tx_idle_en  = ($urandom_range(0, 2) != 0);
      rx_idle_en  = ($urandom_range(0, 2) != 0);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) random_item();
    end
  endtask

  initial begin : run_tests
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_grid();
    test_unit_grid();
    test_oversize_grid();
    test_back_pressure();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && propagated_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0t: %0d mismatches, %0d results outstanding",
               $time, fail_count, propagated_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
